[hw/rtl/pfe_pkg.sv]
// ----------------------------------------------------------------------------
// pfe_pkg
// Shared types and constants of the postfix expression evaluator: stack
// sizing, token codes, operator codes, controller states and the command
// and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package pfe_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int TOKEN_W     = 8;
    localparam int DIV_CNT_W   = $clog2(DATA_W);

    localparam logic [TOKEN_W-1:0] TOK_ADD  = 8'h2B;  // '+'
    localparam logic [TOKEN_W-1:0] TOK_SUB  = 8'h2D;  // '-'
    localparam logic [TOKEN_W-1:0] TOK_MUL  = 8'h2A;  // '*'
    localparam logic [TOKEN_W-1:0] TOK_DIV  = 8'h2F;  // '/'
    localparam logic [TOKEN_W-1:0] TOK_ZERO = 8'h30;  // '0'

    localparam logic [DATA_W-1:0] EMPTY_VALUE = '1;   // -1 on a pop from empty

    // result flag positions in tuser
    localparam int FLAG_UNDER = 0;
    localparam int FLAG_OVER  = 1;
    localparam int FLAG_DIVZ  = 2;
    localparam int FLAG_W     = 3;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_POP_R = 9'b000000010,
        ST_POP_L = 9'b000000100,
        ST_CAP_L = 9'b000001000,
        ST_ALU   = 9'b000010000,
        ST_DIV   = 9'b000100000,
        ST_PUSH  = 9'b001000000,
        ST_FIN   = 9'b010000000,
        ST_EMIT  = 9'b100000000
    } t_state;

    typedef struct packed {
        logic load;    // take the incoming item
        logic pop;     // read top of stack into the read register
        logic cap_r;   // latch right operand from the read register
        logic cap_l;   // latch left operand from the read register
        logic alu;     // compute result or start the divider
        logic push;    // push token value or ALU result
        logic emit;    // load output register, clear stack and flags
    } t_cmd;

    typedef struct packed {
        logic in_is_op;  // incoming token is an operator
        logic is_div;    // held token decodes as divide ('/' or a non-operator)
        logic last;      // held token ends the expression
        logic div_busy;  // divider iterating
        logic out_busy;  // output register holds an untaken result
    } t_sts;

    function automatic logic is_operator(input logic [TOKEN_W-1:0] tok);
        return (tok == TOK_ADD) || (tok == TOK_SUB) ||
               (tok == TOK_MUL) || (tok == TOK_DIV);
    endfunction

    function automatic t_op decode_op(input logic [TOKEN_W-1:0] tok);
        t_op op;
        case (tok)
            TOK_ADD: op = OP_ADD;
            TOK_SUB: op = OP_SUB;
            TOK_MUL: op = OP_MUL;
            default: op = OP_DIV;
        endcase
        return op;
    endfunction

endpackage

[hw/rtl/pfe_ctrl.sv]
// ----------------------------------------------------------------------------
// pfe_ctrl
// Sequencer of the evaluator: steps an operator through pops, ALU or divider
// and push, other items to push; the last item adds final read and hand-off.
// ----------------------------------------------------------------------------
module pfe_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  pfe_pkg::t_sts i_sts,
    output pfe_pkg::t_cmd o_cmd
);

    pfe_pkg::t_state r_state;
    pfe_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pfe_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == pfe_pkg::ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            pfe_pkg::ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.in_is_op ? pfe_pkg::ST_POP_R : pfe_pkg::ST_PUSH;
                end
            end
            pfe_pkg::ST_POP_R: begin
                o_cmd.pop = 1'b1;
                n_state   = pfe_pkg::ST_POP_L;
            end
            pfe_pkg::ST_POP_L: begin
                o_cmd.pop   = 1'b1;
                o_cmd.cap_r = 1'b1;
                n_state     = pfe_pkg::ST_CAP_L;
            end
            pfe_pkg::ST_CAP_L: begin
                o_cmd.cap_l = 1'b1;
                n_state     = pfe_pkg::ST_ALU;
            end
            pfe_pkg::ST_ALU: begin
                o_cmd.alu = 1'b1;
                n_state   = i_sts.is_div ? pfe_pkg::ST_DIV : pfe_pkg::ST_PUSH;
            end
            pfe_pkg::ST_DIV: begin
                if (!i_sts.div_busy) begin
                    n_state = pfe_pkg::ST_PUSH;
                end
            end
            pfe_pkg::ST_PUSH: begin
                o_cmd.push = 1'b1;
                n_state    = i_sts.last ? pfe_pkg::ST_FIN : pfe_pkg::ST_IDLE;
            end
            pfe_pkg::ST_FIN: begin
                o_cmd.pop = 1'b1;
                n_state   = pfe_pkg::ST_EMIT;
            end
            pfe_pkg::ST_EMIT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state    = pfe_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pfe_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/pfe_dpath.sv]
// ----------------------------------------------------------------------------
// pfe_dpath
// Datapath of the evaluator: stack memory and count, error flags, operand
// registers, add/sub/multiply, shift-subtract divider and output register.
// ----------------------------------------------------------------------------
module pfe_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [pfe_pkg::TOKEN_W-1:0]   i_token,
    input  logic                          i_last,
    input  pfe_pkg::t_cmd                 i_cmd,
    output pfe_pkg::t_sts                 o_sts,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [pfe_pkg::DATA_W-1:0]    o_value,
    output logic [pfe_pkg::FLAG_W-1:0]    o_flags
);

    localparam int DW = pfe_pkg::DATA_W;

    logic [DW-1:0] r_mem [pfe_pkg::STACK_DEPTH];

    logic [pfe_pkg::CNT_W-1:0]   r_count;
    logic                        r_under;
    logic                        r_over;
    logic                        r_divz;

    logic [pfe_pkg::TOKEN_W-1:0] r_token;
    logic                        r_last;
    logic                        r_is_op;
    pfe_pkg::t_op                r_op;

    logic [DW-1:0]               r_rd_data;
    logic                        r_rd_empty;
    logic [DW-1:0]               r_a;
    logic [DW-1:0]               r_b;
    logic [DW-1:0]               r_res;

    logic                        r_div_busy;
    logic [pfe_pkg::DIV_CNT_W-1:0] r_div_cnt;
    logic [DW-1:0]               r_dvsr;
    logic [DW-1:0]               r_rem;
    logic [DW-1:0]               r_quo;
    logic                        r_neg;

    logic                        r_out_valid;
    logic [DW-1:0]               r_out_value;
    logic [pfe_pkg::FLAG_W-1:0]  r_out_flags;

    logic [DW-1:0]               rd_val;
    logic [DW-1:0]               alu_res;
    logic [DW-1:0]               mag_a;
    logic [DW-1:0]               mag_b;
    logic [DW:0]                 rem_sh;
    logic [DW:0]                 rem_diff;
    logic [DW-1:0]               quo_next;
    logic [DW-1:0]               rem_next;
    logic [DW-1:0]               push_val;
    logic                        stack_empty;
    logic                        stack_full;

    assign stack_empty = (r_count == '0);
    assign stack_full  = (r_count >= pfe_pkg::CNT_W'(pfe_pkg::STACK_DEPTH));
    assign rd_val      = r_rd_empty ? pfe_pkg::EMPTY_VALUE : r_rd_data;

    assign mag_a = r_a[DW-1] ? (DW'(0) - r_a) : r_a;
    assign mag_b = r_b[DW-1] ? (DW'(0) - r_b) : r_b;

    always_comb begin
        case (r_op)
            pfe_pkg::OP_ADD: alu_res = r_a + r_b;
            pfe_pkg::OP_SUB: alu_res = r_a - r_b;
            pfe_pkg::OP_MUL: alu_res = r_a * r_b;
            default:         alu_res = '0;
        endcase
    end

    // one restoring step per cycle
    assign rem_sh   = {r_rem, r_quo[DW-1]};
    assign rem_diff = rem_sh - {1'b0, r_dvsr};
    assign quo_next = {r_quo[DW-2:0], ~rem_diff[DW]};
    assign rem_next = rem_diff[DW] ? rem_sh[DW-1:0] : rem_diff[DW-1:0];

    assign push_val = r_is_op ? r_res
                              : DW'(r_token) - DW'(pfe_pkg::TOK_ZERO);

    // stack memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.push && !stack_full) begin
            r_mem[r_count[pfe_pkg::ADDR_W-1:0]] <= push_val;
        end
        if (i_cmd.pop) begin
            r_rd_data <= r_mem[pfe_pkg::ADDR_W'(r_count - 1'b1)];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_under     <= 1'b0;
            r_over      <= 1'b0;
            r_divz      <= 1'b0;
            r_div_busy  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.pop) begin
                if (stack_empty) begin
                    r_under <= 1'b1;
                end else begin
                    r_count <= r_count - 1'b1;
                end
            end
            if (i_cmd.push) begin
                if (stack_full) begin
                    r_over <= 1'b1;
                end else begin
                    r_count <= r_count + 1'b1;
                end
            end
            if (i_cmd.alu && r_op == pfe_pkg::OP_DIV) begin
                if (mag_b == '0) begin
                    r_divz <= 1'b1;
                end else begin
                    r_div_busy <= 1'b1;
                end
            end
            if (r_div_busy && r_div_cnt == '1) begin
                r_div_busy <= 1'b0;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
                r_count     <= '0;
                r_under     <= 1'b0;
                r_over      <= 1'b0;
                r_divz      <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_token <= i_token;
            r_last  <= i_last;
            r_is_op <= pfe_pkg::is_operator(i_token);
            r_op    <= pfe_pkg::decode_op(i_token);
        end
        if (i_cmd.pop) begin
            r_rd_empty <= stack_empty;
        end
        if (i_cmd.cap_r) begin
            r_b <= rd_val;
        end
        if (i_cmd.cap_l) begin
            r_a <= rd_val;
        end
        if (i_cmd.alu) begin
            if (r_op == pfe_pkg::OP_DIV) begin
                r_res     <= '0;
                r_dvsr    <= mag_b;
                r_quo     <= mag_a;
                r_rem     <= '0;
                r_neg     <= r_a[DW-1] ^ r_b[DW-1];
                r_div_cnt <= '0;
            end else begin
                r_res <= alu_res;
            end
        end
        if (r_div_busy) begin
            r_quo     <= quo_next;
            r_rem     <= rem_next;
            r_div_cnt <= r_div_cnt + 1'b1;
            if (r_div_cnt == '1) begin
                r_res <= r_neg ? (DW'(0) - quo_next) : quo_next;
            end
        end
        if (i_cmd.emit) begin
            r_out_value <= rd_val;
            r_out_flags[pfe_pkg::FLAG_UNDER] <= r_under;
            r_out_flags[pfe_pkg::FLAG_OVER]  <= r_over;
            r_out_flags[pfe_pkg::FLAG_DIVZ]  <= r_divz;
        end
    end

    assign o_sts.in_is_op = pfe_pkg::is_operator(i_token);
    assign o_sts.is_div   = (r_op == pfe_pkg::OP_DIV);
    assign o_sts.last     = r_last;
    assign o_sts.div_busy = r_div_busy;
    assign o_sts.out_busy = r_out_valid;

    assign o_out_valid = r_out_valid;
    assign o_value     = r_out_value;
    assign o_flags     = r_out_flags;

endmodule

[hw/rtl/postfix_expression_evaluator.sv]
// ----------------------------------------------------------------------------
// postfix_expression_evaluator
// Evaluates postfix expressions one character per item on a 16-entry stack.
// ----------------------------------------------------------------------------
// Each accepted item is one character: + - * / apply to the two top entries
// (left op right, 32-bit wrap, division truncating toward zero), any other
// byte is pushed as its code minus 48. A division by a nonzero divisor runs
// through the 32-step shift-subtract divider, and no new item is taken
// until the current one is done. An item with tlast adds a final read, then
// the top value (-1 if empty) and the error flags leave through an output
// register, and the stack and flags clear. The next item is taken while a
// result waits, but a second result waits until the first has been taken.
module postfix_expression_evaluator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] token
    input  logic        s_axis_tlast,   // last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] value
    output logic [2:0]  m_axis_tuser    // [0] underflow_seen, [1] overflow_seen,
                                        // [2] div_zero_seen
);

    pfe_pkg::t_cmd cmd;
    pfe_pkg::t_sts sts;

    pfe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    pfe_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_token     (s_axis_tdata),
        .i_last      (s_axis_tlast),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_value     (m_axis_tdata),
        .o_flags     (m_axis_tuser)
    );

endmodule

[hw/rtl/pfe_checker.sv]
// ----------------------------------------------------------------------------
// pfe_checker
// Port-level checks of the evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module pfe_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [7:0]  s_axis_tdata,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);

    logic s_acc;
    logic digit_last;

    assign s_acc      = s_axis_tvalid && s_axis_tready;
    assign digit_last = s_axis_tlast &&
                        s_axis_tdata != pfe_pkg::TOK_ADD &&
                        s_axis_tdata != pfe_pkg::TOK_SUB &&
                        s_axis_tdata != pfe_pkg::TOK_MUL &&
                        s_axis_tdata != pfe_pkg::TOK_DIV;

    // an accepted item is never followed by a back-to-back accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> !s_axis_tready)
        else $error("input accepted back to back");

    // a closing non-operator with a free output is pushed, read back and emitted
    a_digit_last_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && digit_last && !m_axis_tvalid) |-> ##4 m_axis_tvalid)
        else $error("result missing after final item");

    // a result is produced only while the input side is busy
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared while idle");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind postfix_expression_evaluator pfe_checker u_pfe_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
